// ===== rtl/core/tkc_pkg.sv =====
// Shared types and codes for the triple-key CAM with masked delete.
package tkc_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 16;
  localparam int COUNT_W      = 7;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
    logic [KEY_W-1:0] key_c;
    logic             any_a;
    logic             any_b;
    logic             any_c;
  } in_req_t;

  typedef struct packed {
    logic               success;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
  } out_res_t;

  // Sweep token handed from cell to cell.
  typedef struct packed {
    logic act;
    logic dup;
    logic free;
  } wave_t;

  // Broadcast from the controller to every cell at the end of a request.
  typedef struct packed {
    logic fin;
    logic ins;
    logic clr;
  } bcast_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_RUN,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/tkc_cell.sv =====
// One table slot: stored triple, valid bit and one stage of the sweep chain.
module tkc_cell #(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tkc_pkg::in_req_t req,
  input  tkc_pkg::bcast_t  bc,
  input  tkc_pkg::wave_t   wave_in,
  input  logic [CNT_W-1:0] cnt_in,
  output tkc_pkg::wave_t   wave_out,
  output logic [CNT_W-1:0] cnt_out
);
  import tkc_pkg::*;

  logic [3*KEY_W-1:0] key_r;
  logic               valid_r;
  logic               cand_r;
  wave_t              wave_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [3*KEY_W-1:0] req_key;
  logic               exact;
  logic               m_hit;
  logic               drop;
  logic               keep;

  always_comb begin
    req_key = {req.key_a, req.key_b, req.key_c};
    exact   = valid_r && (key_r == req_key);
    m_hit   = valid_r &&
              (req.any_a || (key_r[3*KEY_W-1:2*KEY_W] == req.key_a)) &&
              (req.any_b || (key_r[2*KEY_W-1:KEY_W]   == req.key_b)) &&
              (req.any_c || (key_r[KEY_W-1:0]         == req.key_c));
    drop    = wave_in.act && (req.op == OP_DEL) && m_hit;
    keep    = valid_r && !drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= 1'b0;
      wave_r  <= '0;
    end else begin
      priority if (bc.clr) begin
        valid_r <= 1'b0;
      end else if (bc.ins && cand_r) begin
        valid_r <= 1'b1;
      end else if (drop) begin
        valid_r <= 1'b0;
      end else begin
        valid_r <= valid_r;
      end

      // Mark the lowest free slot; the insert waits for the duplicate verdict.
      priority if (bc.fin) begin
        cand_r <= 1'b0;
      end else if (wave_in.act) begin
        cand_r <= (req.op == OP_ADD) && !valid_r && !wave_in.free;
      end else begin
        cand_r <= cand_r;
      end

      wave_r.act  <= wave_in.act;
      wave_r.dup  <= wave_in.dup | exact;
      wave_r.free <= wave_in.free | !valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_in + CNT_W'(keep);
    if (bc.ins && cand_r) begin
      key_r <= req_key;
    end
  end

  assign wave_out = wave_r;
  assign cnt_out  = cnt_r;

endmodule

// ===== rtl/core/triple_key_cam_wildcard_delete.sv =====
// Triple-key CAM top level: request control and the chain of table cells.
//
// Usage: present a request on in_req and raise start; it is taken at a rising
// edge where start is high and busy is low. in_req.op selects add, masked
// delete, query or clear. Every request returns one result on out_res,
// marked by out_valid for exactly one cycle; the receiver cannot stall it.
//
// Add, delete and query send a token down the row of CAPACITY cells, one
// cell per cycle. Each cell compares its stored triple, drops itself on a
// delete hit, marks itself as the insert slot if it is the first free one,
// and adds its valid bit, as left after any drop, into a running count.
// After the token leaves the last cell the controller decides the insert
// and registers the result. Add, delete and query pass through the launch,
// run and finish states; clear goes straight to finish. The result strobe
// follows the finish state. A new request can be taken in the cycle the
// result is shown, and not while one is still running.
// Reset empties the table (all valid bits cleared) at once; no clearing
// pass is needed and the block is ready in the cycle after reset.
module triple_key_cam_wildcard_delete #(
  parameter int CAPACITY = tkc_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tkc_pkg::in_req_t  in_req,
  output logic              out_valid,
  output tkc_pkg::out_res_t out_res
);
  import tkc_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state_r, state_nxt;
  in_req_t          req_r;
  logic             dup_r;
  logic             free_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  out_res_t         out_res_r, res_nxt;
  bcast_t           bc;

  wave_t            wv [CAPACITY+1];
  logic [CNT_W-1:0] cv [CAPACITY+1];

  assign wv[0].act  = (state_r == S_LAUNCH);
  assign wv[0].dup  = 1'b0;
  assign wv[0].free = 1'b0;
  assign cv[0]      = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    tkc_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .bc      (bc),
      .wave_in (wv[g]),
      .cnt_in  (cv[g]),
      .wave_out(wv[g+1]),
      .cnt_out (cv[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    bc        = '0;
    res_nxt   = '{success: 1'b1, status: ST_OK, entry_count: COUNT_W'(cnt_r)};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_req.op == OP_CLEAR) ? S_FINISH : S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (wv[CAPACITY].act) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
        bc.fin    = 1'b1;
        bc.ins    = (req_r.op == OP_ADD) && !dup_r && free_r;
        bc.clr    = (req_r.op == OP_CLEAR);
      end
      default: state_nxt = S_IDLE;
    endcase

    unique case (req_r.op)
      OP_ADD: begin
        priority if (dup_r) begin
          res_nxt.success = 1'b0;
          res_nxt.status  = ST_DUP;
        end else if (!free_r) begin
          res_nxt.success = 1'b0;
          res_nxt.status  = ST_FULL;
        end else begin
          res_nxt.entry_count = COUNT_W'(cnt_r + CNT_W'(1));
        end
      end
      OP_QUERY: begin
        if (!dup_r) begin
          res_nxt.success = 1'b0;
          res_nxt.status  = ST_ABSENT;
        end
      end
      OP_CLEAR: begin
        res_nxt.entry_count = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= in_req;
    end
    // Hold the sweep totals as the token leaves the last cell.
    if (state_r == S_RUN && wv[CAPACITY].act) begin
      dup_r  <= wv[CAPACITY].dup;
      free_r <= wv[CAPACITY].free;
      cnt_r  <= cv[CAPACITY];
    end
    if (state_r == S_FINISH) begin
      out_res_r <= res_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/core/tkc_checker.sv =====
// Port-level checks for the triple-key CAM, bound to the top level.
module tkc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input tkc_pkg::in_req_t  in_req,
  input logic              out_valid,
  input tkc_pkg::out_res_t out_res
);
  import tkc_pkg::*;

  // A taken request holds the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // Results are single-cycle strobes and never shown while a request runs.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_success_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.success == (out_res.status == ST_OK)))
    else $error("success flag disagrees with status");

  // Clear answers with an empty table and an OK status.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.op == OP_CLEAR) |=> ##1
      (out_valid && (out_res.entry_count == '0) && (out_res.status == ST_OK)))
    else $error("clear did not report an empty table");

endmodule

bind triple_key_cam_wildcard_delete tkc_checker u_tkc_checker (.*);
